// File: rtl/i2cadc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cadc_pkg
// Shared types and constants for the I2C ADC read sequencer.
// ----------------------------------------------------------------------------
package i2cadc_pkg;

   // request kinds (req_tuser)
   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_WRITE = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   localparam int unsigned RESULT_BITS_DEF = 18;
   localparam int unsigned CODE_W          = 18;
   localparam int unsigned VOLTS_W         = 28;
   localparam int unsigned RX_W            = 24;

   // one code LSB = 2*2.048 V / 2^18 = 1000/64 uV
   localparam logic signed [VOLTS_W-1:0] SCALE_K = 28'sd1000;

   localparam logic [1:0] GAIN_RESET = 2'd3;

   // line levels and flags for one bus phase
   typedef struct packed {
      logic scl;
      logic sda;
      logic busy;
      logic done;
   } lines_type;

endpackage

// File: rtl/i2cadc_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cadc_seq
// Bus phase sequencer: one phase per enabled step, holds received bytes.
// ----------------------------------------------------------------------------
module i2cadc_seq (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step_en,
   input  logic [1:0]                   action,
   input  logic [7:0]                   addr_byte,
   input  logic [7:0]                   data_byte,
   input  logic                         sda_in,
   output i2cadc_pkg::lines_type        lines,
   output logic [i2cadc_pkg::RX_W-1:0]  rx_bytes_next,
   output logic [7:0]                   status_next
);

   localparam logic [3:0] P_IDLE      = 4'd0;
   localparam logic [3:0] P_START_B   = 4'd1;
   localparam logic [3:0] P_TX_LOW    = 4'd2;
   localparam logic [3:0] P_TX_HIGH   = 4'd3;
   localparam logic [3:0] P_ACK_LOW   = 4'd4;
   localparam logic [3:0] P_ACK_HIGH  = 4'd5;
   localparam logic [3:0] P_RX_LOW    = 4'd6;
   localparam logic [3:0] P_RX_HIGH   = 4'd7;
   localparam logic [3:0] P_MACK_LOW  = 4'd8;
   localparam logic [3:0] P_MACK_HIGH = 4'd9;
   localparam logic [3:0] P_STOP_A    = 4'd10;
   localparam logic [3:0] P_STOP_B    = 4'd11;
   localparam logic [3:0] P_STOP_C    = 4'd12;

   logic [3:0]                  phase_ff, phase_in;
   logic [3:0]                  bit_count_ff, bit_count_in;
   logic [1:0]                  byte_index_ff, byte_index_in;
   logic [7:0]                  shift_ff, shift_in;
   logic                        read_mode_ff, read_mode_in;
   logic [1:0]                  ack_tries_ff, ack_tries_in;
   logic [i2cadc_pkg::RX_W-1:0] rx_bytes_ff, rx_bytes_in;
   logic [7:0]                  status_ff, status_in;
   logic [7:0]                  config_ff, config_in;

   logic [3:0] count_inc;
   logic [7:0] rx_shift;
   logic       last_byte;

   assign count_inc = bit_count_ff + 4'd1;
   assign rx_shift  = {shift_ff[6:0], sda_in};
   assign last_byte = (byte_index_ff == 2'd3);

   always_comb begin
      phase_in      = phase_ff;
      bit_count_in  = bit_count_ff;
      byte_index_in = byte_index_ff;
      shift_in      = shift_ff;
      read_mode_in  = read_mode_ff;
      ack_tries_in  = ack_tries_ff;
      rx_bytes_in   = rx_bytes_ff;
      status_in     = status_ff;
      config_in     = config_ff;
      lines         = '{scl: 1'b1, sda: 1'b1, busy: 1'b1, done: 1'b0};

      case (phase_ff)
         P_START_B: begin
            lines.scl = 1'b0;
            lines.sda = 1'b0;
            phase_in  = P_TX_LOW;
         end
         P_TX_LOW: begin
            lines.scl = 1'b0;
            lines.sda = shift_ff[7];
            phase_in  = P_TX_HIGH;
         end
         P_TX_HIGH: begin
            lines.sda = shift_ff[7];
            shift_in  = {shift_ff[6:0], 1'b0};
            if (count_inc[3]) begin
               bit_count_in = 4'd0;
               ack_tries_in = 2'd0;
               phase_in     = P_ACK_LOW;
            end else begin
               bit_count_in = count_inc;
               phase_in     = P_TX_LOW;
            end
         end
         P_ACK_LOW: begin
            lines.scl = 1'b0;
            phase_in  = P_ACK_HIGH;
         end
         P_ACK_HIGH: begin
            // up to two extra pulses while the slave leaves SDA high
            if (ack_tries_ff != 2'd2 && sda_in) begin
               ack_tries_in = ack_tries_ff + 2'd1;
               phase_in     = P_ACK_LOW;
            end else if (read_mode_ff) begin
               bit_count_in  = 4'd0;
               byte_index_in = 2'd0;
               shift_in      = 8'd0;
               phase_in      = P_RX_LOW;
            end else if (byte_index_ff == 2'd0) begin
               shift_in      = config_ff;
               byte_index_in = 2'd1;
               bit_count_in  = 4'd0;
               phase_in      = P_TX_LOW;
            end else begin
               phase_in = P_STOP_A;
            end
         end
         P_RX_LOW: begin
            lines.scl = 1'b0;
            phase_in  = P_RX_HIGH;
         end
         P_RX_HIGH: begin
            shift_in     = rx_shift;
            bit_count_in = count_inc;
            if (count_inc[3]) begin
               case (byte_index_ff)
                  2'd0:    rx_bytes_in[23:16] = rx_shift;
                  2'd1:    rx_bytes_in[15:8]  = rx_shift;
                  2'd2:    rx_bytes_in[7:0]   = rx_shift;
                  default: status_in          = rx_shift;
               endcase
               phase_in = P_MACK_LOW;
            end else begin
               phase_in = P_RX_LOW;
            end
         end
         P_MACK_LOW: begin
            lines.scl = 1'b0;
            lines.sda = last_byte;  // NACK after the status byte
            phase_in  = P_MACK_HIGH;
         end
         P_MACK_HIGH: begin
            lines.sda = last_byte;
            if (last_byte) begin
               phase_in = P_STOP_A;
            end else begin
               byte_index_in = byte_index_ff + 2'd1;
               bit_count_in  = 4'd0;
               shift_in      = 8'd0;
               phase_in      = P_RX_LOW;
            end
         end
         P_STOP_A: begin
            lines.scl = 1'b0;
            lines.sda = 1'b0;
            phase_in  = P_STOP_B;
         end
         P_STOP_B: begin
            lines.sda = 1'b0;
            phase_in  = P_STOP_C;
         end
         P_STOP_C: begin
            lines.busy = 1'b0;
            lines.done = 1'b1;
            phase_in   = P_IDLE;
         end
         default: begin
            // idle and unused codes
            if (action == i2cadc_pkg::ACT_WRITE || action == i2cadc_pkg::ACT_READ) begin
               shift_in      = addr_byte;
               config_in     = data_byte;
               read_mode_in  = (action == i2cadc_pkg::ACT_READ);
               bit_count_in  = 4'd0;
               byte_index_in = 2'd0;
               ack_tries_in  = 2'd0;
               lines.sda     = 1'b0;
               phase_in      = P_START_B;
            end else begin
               lines.busy = 1'b0;
               phase_in   = P_IDLE;
            end
         end
      endcase
   end

   assign rx_bytes_next = step_en ? rx_bytes_in : rx_bytes_ff;
   assign status_next   = step_en ? status_in : status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= P_IDLE;
         bit_count_ff  <= 4'd0;
         byte_index_ff <= 2'd0;
         shift_ff      <= 8'd0;
         read_mode_ff  <= 1'b0;
         ack_tries_ff  <= 2'd0;
         rx_bytes_ff   <= '0;
         status_ff     <= 8'd0;
         config_ff     <= 8'd0;
      end else if (step_en) begin
         phase_ff      <= phase_in;
         bit_count_ff  <= bit_count_in;
         byte_index_ff <= byte_index_in;
         shift_ff      <= shift_in;
         read_mode_ff  <= read_mode_in;
         ack_tries_ff  <= ack_tries_in;
         rx_bytes_ff   <= rx_bytes_in;
         status_ff     <= status_in;
         config_ff     <= config_in;
      end
   end

   // phase only moves on a step
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !step_en |=> $stable(phase_ff))
      else $error("phase changed without a step");

   // third high SDA in the ack slot does not restart the pulse
   a_ack_limit: assert property (@(posedge clock) disable iff (reset)
      step_en && phase_ff == P_ACK_HIGH && ack_tries_ff == 2'd2 |=> phase_ff != P_ACK_LOW)
      else $error("too many acknowledge retries");

   // status byte ends in stop
   a_last_stop: assert property (@(posedge clock) disable iff (reset)
      step_en && phase_ff == P_MACK_HIGH && byte_index_ff == 2'd3 |=> phase_ff == P_STOP_A)
      else $error("no stop after last byte");

   // done only on the final stop phase, and busy is low then
   a_done: assert property (@(posedge clock) disable iff (reset)
      lines.done |-> phase_ff == P_STOP_C && !lines.busy)
      else $error("done outside stop");

endmodule

// File: rtl/i2cadc_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cadc_scale
// Sign-extends the conversion code and scales it to 1/64 uV.
// ----------------------------------------------------------------------------
module i2cadc_scale #(
   parameter int unsigned RESULT_BITS = i2cadc_pkg::RESULT_BITS_DEF
) (
   input  logic [i2cadc_pkg::RX_W-1:0]           rx_bytes,
   input  logic [1:0]                            gain_shift,
   output logic signed [i2cadc_pkg::CODE_W-1:0]  raw_code,
   output logic signed [i2cadc_pkg::VOLTS_W-1:0] volts_fixed
);

   localparam int unsigned PAD = i2cadc_pkg::CODE_W - RESULT_BITS;

   logic signed [i2cadc_pkg::CODE_W-1:0]  aligned;
   logic signed [i2cadc_pkg::VOLTS_W-1:0] product;

   // move the code MSB to the top, then shift back arithmetically
   assign aligned  = signed'(rx_bytes[i2cadc_pkg::CODE_W-1:0] << PAD);
   assign raw_code = aligned >>> PAD;

   assign product     = i2cadc_pkg::VOLTS_W'(raw_code) * i2cadc_pkg::SCALE_K;
   assign volts_fixed = product >>> gain_shift;  // floor division by gain

endmodule

// File: rtl/i2c_adc_read_sequencer.sv
`timescale 1ns / 1ps
// A request transaction is held in the input register and its result in the result register,
// which drives rsp_tdata; the bus phase logic and scaling between them run in one pass.
// Throughput: one request per cycle while responses are taken (rsp_tready high).
// Every request produces exactly one response transaction.
// Reset (synchronous, active high) returns the bus to idle with both lines high,
// clears the received bytes and sets gain_shift to 3.
// ----------------------------------------------------------------------------
// i2c_adc_read_sequencer
// I2C master for an 18-bit delta-sigma ADC, advanced one bus phase per request.
// ----------------------------------------------------------------------------
module i2c_adc_read_sequencer #(
   parameter int unsigned RESULT_BITS = i2cadc_pkg::RESULT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request: tuser[1:0] action
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,
   // request: [7:0] device_addr_byte, [15:8] data_byte, [16] sda_in, rest zero
   input  logic [23:0] req_tdata,
   // response: [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res,
   // [21:4] raw_code, [49:22] volts_fixed, [57:50] status_byte, rest zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,
   // gain_shift register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_data
);

   // input register
   logic        in_valid_ff, in_valid_in;
   logic [1:0]  in_action_ff;
   logic [7:0]  in_addr_ff;
   logic [7:0]  in_data_ff;
   logic        in_sda_ff;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_data_ff;

   logic [1:0]  gain_ff;

   logic                                  advance;
   i2cadc_pkg::lines_type                 lines;
   logic [i2cadc_pkg::RX_W-1:0]           rx_bytes_next;
   logic [7:0]                            status_next;
   logic signed [i2cadc_pkg::CODE_W-1:0]  raw_code;
   logic signed [i2cadc_pkg::VOLTS_W-1:0] volts_fixed;

   // the held request moves on whenever the result slot is free or draining
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         gain_ff      <= i2cadc_pkg::GAIN_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            gain_ff <= csr_data;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_action_ff <= req_tuser;
         in_addr_ff   <= req_tdata[7:0];
         in_data_ff   <= req_tdata[15:8];
         in_sda_ff    <= req_tdata[16];
      end
      if (advance) begin
         rsp_data_ff <= {6'd0, status_next, volts_fixed, raw_code,
                         lines.done, lines.busy, lines.sda, lines.scl};
      end
   end

   // bus phase state machine
   i2cadc_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .step_en       (advance),
      .action        (in_action_ff),
      .addr_byte     (in_addr_ff),
      .data_byte     (in_data_ff),
      .sda_in        (in_sda_ff),
      .lines         (lines),
      .rx_bytes_next (rx_bytes_next),
      .status_next   (status_next)
   );

   // code extraction and scaling, from the bytes as they stand after this phase
   i2cadc_scale #(
      .RESULT_BITS (RESULT_BITS)
   ) u_scale (
      .rx_bytes    (rx_bytes_next),
      .gain_shift  (gain_ff),
      .raw_code    (raw_code),
      .volts_fixed (volts_fixed)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;  // the user writes gain_shift only while idle; the block does not enforce this

endmodule
